// ===== rtl/core/bzdc_pkg.sv =====
// Shared types, constants and the interpolation function for the Bezier evaluator.
// No dependencies; every other file of the block imports this package.
package bzdc_pkg;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int T_W      = 17;
    localparam int FRAC_W   = 16;
    localparam int IDX_W    = 3;
    localparam int DEG_W    = 3;
    localparam int NCOMP    = 4;

    // Parameter defaults and limits
    localparam int MAX_DEGREE_DEF = 7;
    localparam int POS_W          = 4;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;

    // Parameter value meaning one
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Component positions inside a point
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    typedef logic [NCOMP-1:0][COORD_W-1:0] t_point;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             start;
        logic             step;
        logic             last;
        logic [POS_W-1:0] wr_pos;
        logic             capture;
    } t_dp_cmd;

    // a + floor(t * (b - a) / 2^16); result lies between a and b for t up to one
    function automatic logic [COORD_W-1:0] lerp(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [T_W-1:0] t);
        logic signed [COORD_W:0]             diff;
        logic signed [COORD_W+T_W+1:0]       prod;
        logic signed [COORD_W+2:0]           sum;
        diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        prod = diff * $signed({1'b0, t});
        sum  = $signed({{3{a[COORD_W-1]}}, a}) + prod[COORD_W+T_W+1:FRAC_W];
        return sum[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/bzdc_ifs.sv =====
// Request and result channel interfaces of the Bezier evaluator.
// Depends on bzdc_pkg for field widths.
interface bzdc_req_if;
    import bzdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic        [IDX_W-1:0]   point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_w;
    logic        [T_W-1:0]     param_t;

    modport source (output valid, req_type, point_index, point_x, point_y, point_z,
                    point_w, param_t, input ready);
    modport sink   (input valid, req_type, point_index, point_x, point_y, point_z,
                    point_w, param_t, output ready);
endinterface

interface bzdc_res_if;
    import bzdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
    logic signed [COORD_W-1:0] curve_w;

    modport source (output valid, curve_x, curve_y, curve_z, curve_w, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, curve_w, output ready);
endinterface

// ===== rtl/core/bzdc_ctrl.sv =====
// Controller of the Bezier evaluator: sequences the interpolation triangle and
// owns the request/result handshakes. Depends on bzdc_pkg.
module bzdc_ctrl #(
    parameter int MAX_DEGREE = bzdc_pkg::MAX_DEGREE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_req_type,
    input  logic [bzdc_pkg::DEG_W-1:0] i_degree,
    input  logic                       i_out_ready,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    output bzdc_pkg::t_dp_cmd          o_cmd
);
    import bzdc_pkg::*;

    localparam int LEN_W = $clog2(MAX_DEGREE + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_step;
    logic [LEN_W-1:0]   n_len_init;
    logic               accept;
    logic               last;

    // Clamp the degree and turn it into the first row length
    always_comb begin
        if (int'(i_degree) > MAX_DEGREE) begin
            n_len_init = LEN_W'(MAX_DEGREE + 1);
        end else begin
            n_len_init = LEN_W'(i_degree) + LEN_W'(1);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign last        = (r_step == r_len - LEN_W'(2));

    // Datapath commands
    always_comb begin
        o_cmd.load    = accept && (i_req_type == REQ_LOAD);
        o_cmd.start   = accept && (i_req_type == REQ_EVAL);
        o_cmd.step    = (r_state == S_RUN);
        o_cmd.last    = last;
        o_cmd.wr_pos  = last ? POS_W'(r_len - LEN_W'(2)) : POS_W'(r_len - LEN_W'(1));
        o_cmd.capture = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    // State, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_step      <= '0;
        end else begin
            // drop the result once taken, load a fresh one on capture
            r_out_valid <= o_cmd.capture || (r_out_valid && !i_out_ready);

            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.start) begin
                        r_len  <= n_len_init;
                        r_step <= '0;
                        r_state <= (n_len_init == LEN_W'(1)) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    // advance one interpolation; close the row on its last pair
                    if (last) begin
                        r_len  <= r_len - LEN_W'(1);
                        r_step <= '0;
                        if (r_len == LEN_W'(2)) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_step <= r_step + LEN_W'(1);
                    end
                end
                S_DONE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/bzdc_dpath.sv =====
// Datapath of the Bezier evaluator: control point store, working shift line,
// four interpolators and the result register. Depends on bzdc_pkg.
module bzdc_dpath #(
    parameter int MAX_DEGREE = bzdc_pkg::MAX_DEGREE_DEF
) (
    input  logic                                i_clk,
    input  bzdc_pkg::t_dp_cmd                   i_cmd,
    input  logic        [bzdc_pkg::IDX_W-1:0]   i_point_index,
    input  logic signed [bzdc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [bzdc_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [bzdc_pkg::COORD_W-1:0] i_point_z,
    input  logic signed [bzdc_pkg::COORD_W-1:0] i_point_w,
    input  logic        [bzdc_pkg::T_W-1:0]     i_param_t,
    output logic signed [bzdc_pkg::COORD_W-1:0] o_curve_x,
    output logic signed [bzdc_pkg::COORD_W-1:0] o_curve_y,
    output logic signed [bzdc_pkg::COORD_W-1:0] o_curve_z,
    output logic signed [bzdc_pkg::COORD_W-1:0] o_curve_w
);
    import bzdc_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;

    t_point          r_store [DEPTH];
    t_point          r_work  [DEPTH];
    t_point          r_curve;
    logic [T_W-1:0]  r_t;
    t_point          ld_pt;
    t_point          n_res;
    logic [T_W-1:0]  n_t;

    // Gather the loaded point
    always_comb begin
        ld_pt     = '0;
        ld_pt[CX] = i_point_x;
        ld_pt[CY] = i_point_y;
        ld_pt[CZ] = i_point_z;
        ld_pt[CW] = i_point_w;
    end

    // Saturate t above one
    assign n_t = (i_param_t[T_W-1] && (|i_param_t[T_W-2:0])) ? T_ONE : i_param_t;

    // Interpolate the two head entries, one per component
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            n_res[c] = lerp(r_work[0][c], r_work[1][c], r_t);
        end
    end

    // Per entry: store write, copy to the work line, shift and insert
    for (genvar k = 0; k < DEPTH; k++) begin : g_lane
        localparam int S1 = (k + 1 < DEPTH) ? k + 1 : k;
        localparam int S2 = (k + 2 < DEPTH) ? k + 2 : k;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load && (POS_W'(i_point_index) == POS_W'(k))) begin
                r_store[k] <= ld_pt;
            end
            if (i_cmd.start) begin
                r_work[k] <= r_store[k];
            end else if (i_cmd.step) begin
                if (i_cmd.wr_pos == POS_W'(k)) begin
                    r_work[k] <= n_res;
                end else if (i_cmd.last) begin
                    r_work[k] <= r_work[S2];
                end else begin
                    r_work[k] <= r_work[S1];
                end
            end
        end
    end

    // Hold t for the evaluation and capture the finished point
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t <= n_t;
        end
        if (i_cmd.capture) begin
            r_curve <= r_work[0];
        end
    end

    assign o_curve_x = $signed(r_curve[CX]);
    assign o_curve_y = $signed(r_curve[CY]);
    assign o_curve_z = $signed(r_curve[CZ]);
    assign o_curve_w = $signed(r_curve[CW]);

endmodule

// ===== rtl/core/bezier_de_casteljau_eval.sv =====
// Top level of the homogeneous Bezier curve evaluator (de Casteljau scheme).
// Depends on bzdc_pkg, bzdc_ifs, bzdc_ctrl and bzdc_dpath.
//
//   Channel   Dir   Handshake          Payload
//   i_req     in    valid/ready        req_type, point_index, point_x..w, param_t
//   o_res     out   valid/ready        curve_x, curve_y, curve_z, curve_w
//   i_cfg     in    i_cfg_wr_en        i_cfg_wr_data (curve degree)
//
// An evaluate walks the interpolation triangle with the single four-component
// interpolator, one pair per cycle, then captures the finished point.
// Reset (synchronous, active low) clears the controller and sets the degree to 3.
// The finished point waits in an output register; loads are still accepted then,
// and a new evaluate stalls only at its capture step until the result is taken.
module bezier_de_casteljau_eval #(
    parameter int MAX_DEGREE = bzdc_pkg::MAX_DEGREE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bzdc_req_if.sink                   i_req,
    bzdc_res_if.source                 o_res,
    input  logic                       i_cfg_wr_en,
    input  logic [bzdc_pkg::DEG_W-1:0] i_cfg_wr_data
);
    import bzdc_pkg::*;

    logic [DEG_W-1:0] r_degree;
    t_dp_cmd          cmd;
    logic             in_ready;
    logic             out_valid;

    // Degree register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
        end else if (i_cfg_wr_en) begin
            r_degree <= i_cfg_wr_data;
        end
    end

    bzdc_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_degree    (r_degree),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    bzdc_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_point_index (i_req.point_index),
        .i_point_x     (i_req.point_x),
        .i_point_y     (i_req.point_y),
        .i_point_z     (i_req.point_z),
        .i_point_w     (i_req.point_w),
        .i_param_t     (i_req.param_t),
        .o_curve_x     (o_res.curve_x),
        .o_curve_y     (o_res.curve_y),
        .o_curve_z     (o_res.curve_z),
        .o_curve_w     (o_res.curve_w)
    );

    assign i_req.ready = in_ready;
    assign o_res.valid = out_valid;

`ifndef SYNTH
    // An evaluate occupies the block: no transfer in the following cycle
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.req_type == REQ_EVAL)) |=> !i_req.ready)
        else $error("request accepted right after an evaluate");

    // A load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.req_type == REQ_LOAD) && !o_res.valid)
        |=> !o_res.valid)
        else $error("result raised by a load");

    // A result appears only after evaluate work, never straight from idle
    a_capture_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (!in_ready && !cmd.step))
        else $error("capture outside the finish step");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for bezier_de_casteljau_eval: loads control points,
// evaluates curves at several degrees and checks every point against an own predictor.
// Depends on bzdc_pkg, bzdc_ifs and the RTL of the evaluator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bzdc_pkg::*;

    localparam int STORE_N     = MAX_DEGREE_DEF + 1;
    localparam int SETTLE_CYC  = 32;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] idx;
        t_point           pt;
        logic [T_W-1:0]   param;
    } t_bez_req;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [DEG_W-1:0] cfg_wr_data;

    bzdc_req_if req_ch ();
    bzdc_res_if res_ch ();

    bezier_de_casteljau_eval dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .o_res        (res_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    // Predictor state: control point copy and current degree
    t_point           ctrl_pts [STORE_N];
    logic [DEG_W-1:0] degree_now;

    t_bez_req pending_reqs [$];
    t_point   curve_pts_due [$];

    int  n_fail;
    int  src_gap, src_calm, snk_gap, snk_calm;
    int  quiet_cycles;
    bit  no_idle;

    string comp_name [NCOMP] = '{"curve_x", "curve_y", "curve_z", "curve_w"};

    // a + floor(t * (b - a) / 2^16) in 64-bit arithmetic
    function automatic longint blend(longint a, longint b, longint tp);
        return a + ((tp * (b - a)) >>> FRAC_W);
    endfunction

    // Walk the de Casteljau triangle over points 0..degree for each component
    function automatic t_point curve_point(logic [T_W-1:0] param);
        longint work [STORE_N];
        longint tp;
        int     d;
        t_point res;
        d  = degree_now;
        tp = (param > T_ONE) ? longint'(T_ONE) : longint'(param);
        for (int k = 0; k < NCOMP; k++) begin
            for (int i = 0; i <= d; i++) work[i] = longint'($signed(ctrl_pts[i][k]));
            for (int r = 1; r <= d; r++)
                for (int i = 0; i + r <= d; i++) work[i] = blend(work[i], work[i+1], tp);
            res[k] = work[0][COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return T_ONE;
            2:       return T_W'($urandom_range(T_ONE + 1, 2**T_W - 1));
            default: return T_W'($urandom_range(0, T_ONE));
        endcase
    endfunction

    task automatic push_load(int idx, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic [COORD_W-1:0] w);
        t_bez_req r;
        r          = '0;
        r.req_type = REQ_LOAD;
        r.idx      = IDX_W'(idx);
        r.pt[CX]   = x;
        r.pt[CY]   = y;
        r.pt[CZ]   = z;
        r.pt[CW]   = w;
        r.param    = T_W'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic push_eval(logic [T_W-1:0] param);
        t_bez_req r;
        r          = '0;
        r.req_type = REQ_EVAL;
        r.idx      = IDX_W'($urandom);
        r.pt       = {$urandom, $urandom, $urandom, $urandom};
        r.param    = param;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0)
                push_load($urandom_range(0, STORE_N - 1), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord());
            else
                push_eval(rand_param());
        end
    endtask

    // Hold until every request is accepted and every point has come back, then settle
    task automatic drain();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || curve_pts_due.size() != 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_degree(int d);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= DEG_W'(d);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        degree_now  = DEG_W'(d);
        @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: retire the transfer, then hold, idle or present the next item
    always @(posedge clk) begin
        t_bez_req cur;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            src_gap  = 0;
            src_calm = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                if (req_ch.req_type == REQ_LOAD) begin
                    ctrl_pts[req_ch.point_index] = {req_ch.point_w, req_ch.point_z,
                                                    req_ch.point_y, req_ch.point_x};
                end else begin
                    curve_pts_due.push_back(curve_point(req_ch.param_t));
                end
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold the item until it is taken
            end else if (src_gap > 0) begin
                src_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (!no_idle && src_calm == 0 && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 14) - 1;
                if ($urandom_range(0, 9) == 0) src_calm = $urandom_range(20, 120);
                req_ch.valid <= 1'b0;
            end else begin
                cur = pending_reqs.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= cur.req_type;
                req_ch.point_index <= cur.idx;
                req_ch.point_x     <= cur.pt[CX];
                req_ch.point_y     <= cur.pt[CY];
                req_ch.point_z     <= cur.pt[CZ];
                req_ch.point_w     <= cur.pt[CW];
                req_ch.param_t     <= cur.param;
            end
            if (src_calm > 0) src_calm--;
        end
    end

    // Result monitor: compare each transfer with the oldest predicted point
    always @(posedge clk) begin
        t_point want, got;
        logic   rdy;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap  = 0;
            snk_calm = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got[CX] = res_ch.curve_x;
                got[CY] = res_ch.curve_y;
                got[CZ] = res_ch.curve_z;
                got[CW] = res_ch.curve_w;
                if (curve_pts_due.size() == 0) begin
                    $display("%0t: unexpected curve point, expected none got %h", $time, got);
                    n_fail++;
                end else begin
                    want = curve_pts_due.pop_front();
                    for (int k = 0; k < NCOMP; k++) begin
                        if (got[k] !== want[k]) begin
                            $display("%0t: %s mismatch, expected %h got %h", $time,
                                     comp_name[k], want[k], got[k]);
                            n_fail++;
                        end
                    end
                end
            end
            // stall in random bursts, with calm stretches
            if (snk_gap > 0) begin
                snk_gap--;
                rdy = 1'b0;
            end else if (!no_idle && snk_calm == 0 && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 14) - 1;
                if ($urandom_range(0, 9) == 0) snk_calm = $urandom_range(20, 120);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            res_ch.ready <= rdy;
            if (snk_calm > 0) snk_calm--;
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int deg_plan [10] = '{5, 2, 7, 0, 4, 1, 6, 3, 7, 2};

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.point_index = '0;
        req_ch.point_x     = '0;
        req_ch.point_y     = '0;
        req_ch.point_z     = '0;
        req_ch.point_w     = '0;
        req_ch.param_t     = '0;
        res_ch.ready       = 1'b0;
        n_fail             = 0;
        no_idle            = 1'b0;
        quiet_cycles       = 0;
        degree_now         = DEGREE_RESET;
        foreach (ctrl_pts[i]) ctrl_pts[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole store first so no evaluate ever reads an unwritten entry;
        // alternate the extremes so neighbor differences span the full range
        push_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000);
        push_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_load(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 32'h8000_0000);
        push_load(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_0001);
        push_load(4, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'hFFFF_0000);
        push_load(5, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        push_load(6, 32'h7FFF_FFFF, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555);
        push_load(7, 32'h8000_0000, 32'h8765_4321, 32'h7FFF_FFFF, 32'h8000_0000);

        // Reset degree: ends of t, one step off each end, half, and t above one
        push_eval(17'd0);
        push_eval(T_ONE);
        push_eval(17'd1);
        push_eval(T_ONE - 17'd1);
        push_eval(17'h08000);
        push_eval(17'h1FFFF);
        push_eval(T_ONE + 17'd1);
        drain();

        // Degree zero returns point 0 as loaded
        write_degree(0);
        push_eval(17'd12345);
        push_eval(17'h1FFFF);
        drain();

        // Highest degree, reload the last entry on the way
        write_degree(MAX_DEGREE_DEF);
        push_load(7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_eval(T_ONE - 17'd1);
        push_eval(17'd1);
        push_eval(17'h18000);
        drain();

        write_degree(1);
        push_eval(17'h08000);
        push_eval(T_ONE);
        drain();

        // Random phases, one degree each; pause for all points between them
        foreach (deg_plan[p]) begin
            write_degree(deg_plan[p]);
            push_random(180);
            drain();
        end

        // Final stretch at full rate on both sides
        no_idle = 1'b1;
        push_random(150);
        drain();

        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
